// File: hw/rtl/assert_macros.svh
// Assertion macros for the RTL; empty when synthesizing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check, switched off while reset is high.
`define RCRB_ASSERT(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (prop)) else $error(msg);

// Clocked check that also holds across reset.
`define RCRB_ASSERT_ALWAYS(lbl, clk_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) (prop)) else $error(msg);

`else

`define RCRB_ASSERT(lbl, clk_sig, rst_sig, prop, msg)
`define RCRB_ASSERT_ALWAYS(lbl, clk_sig, prop, msg)

`endif

`endif

// File: hw/rtl/rcrb_pkg.sv
// Shared types, constants and ramp tables of the rainfall color ramp blend.
package rcrb_pkg;

  localparam int RAIN_FRAC_BITS_DEF = 16;
  localparam int HEIGHT_BITS_DEF    = 16;

  localparam int NUM_STAGES = 7;
  localparam int NUM_CHAN   = 3;
  localparam int CHAN_W     = 8;
  localparam int CHAN_TOP   = 255;
  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pixel_t;

  // Ramp segments: lower breakpoint and span in hundredths, end colors.
  localparam int NUM_SEG   = 6;
  localparam int PCT_SCALE = 100;
  typedef logic [2:0] seg_idx_t;

  localparam int SEG_LO   [NUM_SEG] = '{0, 15, 30, 50, 70, 85};
  localparam int SEG_SPAN [NUM_SEG] = '{15, 15, 20, 20, 15, 15};
  localparam int SEG_C0 [NUM_SEG][NUM_CHAN] = '{
    '{139,  69,  19}, '{210, 180, 140}, '{255, 215,   0},
    '{144, 238, 144}, '{ 34, 139,  34}, '{  0, 206, 209}
  };
  localparam int SEG_C1 [NUM_SEG][NUM_CHAN] = '{
    '{210, 180, 140}, '{255, 215,   0}, '{144, 238, 144},
    '{ 34, 139,  34}, '{  0, 206, 209}, '{ 25,  25, 112}
  };

  // Reciprocal divide: q = (x * RECIP) >> RECIP_SHIFT, then one correction.
  localparam int RECIP_SHIFT = 16;
  localparam int SEG_RECIP_W = 13;
  localparam int SEG_RECIP [NUM_SEG] = '{
    (1 << 16) / 15, (1 << 16) / 15, (1 << 16) / 20,
    (1 << 16) / 20, (1 << 16) / 15, (1 << 16) / 15
  };
  localparam int DELTA_W    = 9;   // signed color step
  localparam int SPAN_SUM_W = 14;  // biased segment quotient dividend
  localparam int QUOT_W     = 9;   // biased segment quotient

  // Terrain grey divider.
  localparam int GREY_STAGES = 4;
  localparam int GREY_STEPS  = CHAN_W / GREY_STAGES;

  // Blend and darken.
  localparam int MIX_W           = 15;
  localparam int BLEND_RAMP_GAIN = 7;
  localparam int BLEND_GREY_GAIN = 3;
  localparam int BLEND_DIV       = 10;
  localparam int DARK_GAIN       = 85;
  localparam int DARK_DIV        = 100;
  localparam int PASS_DIV        = 1;
  localparam int MIX_RECIP_W     = 17;
  localparam int BLEND_RECIP     = (1 << 16) / 10;
  localparam int DARK_RECIP      = (1 << 16) / 100;
  localparam int PASS_RECIP      = 1 << 16;
  localparam int MIX_PROD_W      = 32;

  typedef enum logic [1:0] {
    MODE_PASS  = 2'b00,
    MODE_BLEND = 2'b01,
    MODE_DARK  = 2'b10
  } mix_mode_t;

  // Configuration register indexes.
  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_OVERLAY_ENABLE = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_ELEVATION  = 1'b1;

  // Per-stage load enables, stage 1 in the low bit.
  typedef struct packed {
    logic s7;
    logic s6;
    logic s5;
    logic s4;
    logic s3;
    logic s2;
    logic s1;
  } stage_en_t;

endpackage

// File: hw/rtl/rcrb_ramp.sv
// Ramp color pipeline: clamp and segment pick, channel products, reciprocal divide.
module rcrb_ramp #(
  parameter int RAIN_FRAC_BITS = rcrb_pkg::RAIN_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  rcrb_pkg::stage_en_t   en,
  input  logic [RAIN_FRAC_BITS:0] rain_level,
  input  logic                  land_flag,
  input  logic                  overlay_enable,
  output rcrb_pkg::pixel_t      chan,
  output rcrb_pkg::mix_mode_t   mode
);

  localparam int F      = RAIN_FRAC_BITS;
  localparam int R100_W = F + 7;
  localparam int NUM_W  = F + 5;
  localparam int PROD_W = NUM_W + 1 + rcrb_pkg::DELTA_W;
  localparam int QMUL_W = rcrb_pkg::SPAN_SUM_W + rcrb_pkg::SEG_RECIP_W;
  localparam int CSUM_W = rcrb_pkg::QUOT_W + 1;
  localparam longint ONE_L = longint'(1) << F;
  localparam logic [F:0] RAIN_ONE = (F + 1)'(ONE_L);

  // Lowest level of each segment: ceil(lo * ONE / 100).
  localparam longint THR [rcrb_pkg::NUM_SEG] = '{
    0,
    (rcrb_pkg::SEG_LO[1] * ONE_L + rcrb_pkg::PCT_SCALE - 1) / rcrb_pkg::PCT_SCALE,
    (rcrb_pkg::SEG_LO[2] * ONE_L + rcrb_pkg::PCT_SCALE - 1) / rcrb_pkg::PCT_SCALE,
    (rcrb_pkg::SEG_LO[3] * ONE_L + rcrb_pkg::PCT_SCALE - 1) / rcrb_pkg::PCT_SCALE,
    (rcrb_pkg::SEG_LO[4] * ONE_L + rcrb_pkg::PCT_SCALE - 1) / rcrb_pkg::PCT_SCALE,
    (rcrb_pkg::SEG_LO[5] * ONE_L + rcrb_pkg::PCT_SCALE - 1) / rcrb_pkg::PCT_SCALE
  };

  // Stage 1: clamp, segment, offset into segment.
  logic [F:0]          r_clamp;
  logic [R100_W-1:0]   r100;
  logic [R100_W-1:0]   lo_scaled;
  rcrb_pkg::seg_idx_t  seg_sel;
  rcrb_pkg::mix_mode_t mode_sel;

  logic [NUM_W-1:0]    s1_num;
  rcrb_pkg::seg_idx_t  s1_seg;
  rcrb_pkg::mix_mode_t s1_mode;

  always_comb begin
    r_clamp = (rain_level > RAIN_ONE) ? RAIN_ONE : rain_level;
    seg_sel = '0;
    for (int s = 1; s < rcrb_pkg::NUM_SEG; s++) begin
      if (r_clamp >= (F + 1)'(THR[s])) begin
        seg_sel = 3'(s);
      end
    end
    r100      = R100_W'(r_clamp) * R100_W'(rcrb_pkg::PCT_SCALE);
    lo_scaled = R100_W'(longint'(rcrb_pkg::SEG_LO[seg_sel]) << F);
    if (!land_flag) begin
      mode_sel = rcrb_pkg::MODE_DARK;
    end else if (overlay_enable) begin
      mode_sel = rcrb_pkg::MODE_BLEND;
    end else begin
      mode_sel = rcrb_pkg::MODE_PASS;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      s1_num  <= NUM_W'(r100 - lo_scaled);
      s1_seg  <= seg_sel;
      s1_mode <= mode_sel;
    end
  end

  // Stage 2: signed color step times offset.
  logic signed [rcrb_pkg::DELTA_W-1:0] delta [rcrb_pkg::NUM_CHAN];
  logic signed [PROD_W-1:0] prod_next [rcrb_pkg::NUM_CHAN];
  logic signed [PROD_W-1:0] s2_prod   [rcrb_pkg::NUM_CHAN];
  rcrb_pkg::seg_idx_t       s2_seg;
  rcrb_pkg::mix_mode_t      s2_mode;

  always_comb begin
    for (int k = 0; k < rcrb_pkg::NUM_CHAN; k++) begin
      delta[k] = rcrb_pkg::DELTA_W'(rcrb_pkg::SEG_C1[s1_seg][k] - rcrb_pkg::SEG_C0[s1_seg][k]);
      prod_next[k] = $signed({1'b0, s1_num}) * delta[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      for (int k = 0; k < rcrb_pkg::NUM_CHAN; k++) begin
        s2_prod[k] <= prod_next[k];
      end
      s2_seg  <= s1_seg;
      s2_mode <= s1_mode;
    end
  end

  // Stage 3: floor by 2^F, bias to non-negative, reciprocal estimate of / span.
  logic [rcrb_pkg::SPAN_SUM_W-1:0] sp_next [rcrb_pkg::NUM_CHAN];
  logic [QMUL_W-1:0]               qmul    [rcrb_pkg::NUM_CHAN];
  logic [rcrb_pkg::SPAN_SUM_W-1:0] s3_sp   [rcrb_pkg::NUM_CHAN];
  logic [rcrb_pkg::QUOT_W-1:0]     s3_q0   [rcrb_pkg::NUM_CHAN];
  rcrb_pkg::seg_idx_t              s3_seg;
  rcrb_pkg::mix_mode_t             s3_mode;

  always_comb begin
    for (int k = 0; k < rcrb_pkg::NUM_CHAN; k++) begin
      sp_next[k] = rcrb_pkg::SPAN_SUM_W'(s2_prod[k] >>> F)
                 + rcrb_pkg::SPAN_SUM_W'(rcrb_pkg::CHAN_TOP * rcrb_pkg::SEG_SPAN[s2_seg]);
      qmul[k] = QMUL_W'(sp_next[k]) * QMUL_W'(rcrb_pkg::SEG_RECIP[s2_seg]);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      for (int k = 0; k < rcrb_pkg::NUM_CHAN; k++) begin
        s3_sp[k] <= sp_next[k];
        s3_q0[k] <= rcrb_pkg::QUOT_W'(qmul[k] >> rcrb_pkg::RECIP_SHIFT);
      end
      s3_seg  <= s2_seg;
      s3_mode <= s2_mode;
    end
  end

  // Stage 4: quotient correction, remove bias, add start color.
  logic [rcrb_pkg::SPAN_SUM_W-1:0] qspan [rcrb_pkg::NUM_CHAN];
  logic [rcrb_pkg::SPAN_SUM_W-1:0] rem   [rcrb_pkg::NUM_CHAN];
  logic [CSUM_W-1:0]               csum  [rcrb_pkg::NUM_CHAN];
  rcrb_pkg::pixel_t                s4_chan;
  rcrb_pkg::mix_mode_t             s4_mode;

  always_comb begin
    for (int k = 0; k < rcrb_pkg::NUM_CHAN; k++) begin
      qspan[k] = rcrb_pkg::SPAN_SUM_W'(s3_q0[k] * rcrb_pkg::SEG_SPAN[s3_seg]);
      rem[k]   = s3_sp[k] - qspan[k];
      csum[k]  = CSUM_W'(s3_q0[k])
               + CSUM_W'(rem[k] >= rcrb_pkg::SPAN_SUM_W'(rcrb_pkg::SEG_SPAN[s3_seg]))
               + CSUM_W'(rcrb_pkg::SEG_C0[s3_seg][k])
               - CSUM_W'(rcrb_pkg::CHAN_TOP);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      for (int k = 0; k < rcrb_pkg::NUM_CHAN; k++) begin
        s4_chan[k] <= csum[k][rcrb_pkg::CHAN_W-1:0];
      end
      s4_mode <= s3_mode;
    end
  end

  assign chan = s4_chan;
  assign mode = s4_mode;

endmodule

// File: hw/rtl/rcrb_grey.sv
// Terrain grey: pipelined restoring divide of 255 * height by max elevation.
module rcrb_grey #(
  parameter int HEIGHT_BITS = rcrb_pkg::HEIGHT_BITS_DEF
) (
  input  logic                   clk,
  input  rcrb_pkg::stage_en_t    en,
  input  logic [HEIGHT_BITS-1:0] height_sample,
  input  logic [HEIGHT_BITS-1:0] max_elevation,
  output rcrb_pkg::chan_t        grey
);

  localparam int NUM_W  = HEIGHT_BITS + rcrb_pkg::CHAN_W;
  localparam int STAGES = rcrb_pkg::GREY_STAGES;
  localparam int STEPS  = rcrb_pkg::GREY_STEPS;

  logic [NUM_W-1:0]            rem [0:STAGES];
  rcrb_pkg::chan_t             quo [0:STAGES];
  logic                        sat [0:STAGES];
  logic [NUM_W-1:0]            rem_c [STAGES];
  rcrb_pkg::chan_t             quo_c [STAGES];
  logic [NUM_W-1:0]            dvs;
  logic [STAGES-1:0]           ld;

  assign dvs = NUM_W'(max_elevation);
  assign ld  = {en.s5, en.s4, en.s3, en.s2};

  // Two quotient bits per stage, MSB first; h >= m (or m == 0) saturates.
  always_comb begin
    for (int j = 0; j < STAGES; j++) begin
      rem_c[j] = rem[j];
      quo_c[j] = quo[j];
      for (int t = 0; t < STEPS; t++) begin
        if (rem_c[j] >= (dvs << (rcrb_pkg::CHAN_W - 1 - j * STEPS - t))) begin
          rem_c[j] = rem_c[j] - (dvs << (rcrb_pkg::CHAN_W - 1 - j * STEPS - t));
          quo_c[j][rcrb_pkg::CHAN_W - 1 - j * STEPS - t] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      rem[0] <= (NUM_W'(height_sample) << rcrb_pkg::CHAN_W) - NUM_W'(height_sample);
      quo[0] <= '0;
      sat[0] <= (max_elevation == '0) || (height_sample >= max_elevation);
    end
    for (int j = 0; j < STAGES; j++) begin
      if (ld[j]) begin
        rem[j + 1] <= rem_c[j];
        quo[j + 1] <= quo_c[j];
        sat[j + 1] <= sat[j];
      end
    end
  end

  assign grey = sat[STAGES] ? rcrb_pkg::CHAN_MAX : quo[STAGES];

endmodule

// File: hw/rtl/rcrb_blend.sv
// Output mix: terrain blend, darken or pass; reciprocal divide by 10, 100, 1.
module rcrb_blend (
  input  logic                clk,
  input  rcrb_pkg::stage_en_t en,
  input  rcrb_pkg::pixel_t    chan_in,
  input  rcrb_pkg::mix_mode_t mode_in,
  input  rcrb_pkg::chan_t     grey,
  output rcrb_pkg::pixel_t    chan_out
);

  localparam int MW = rcrb_pkg::MIX_W;

  // Stage 5: scale ramp color.
  logic [MW-1:0]       a_next [rcrb_pkg::NUM_CHAN];
  logic [MW-1:0]       s5_a   [rcrb_pkg::NUM_CHAN];
  rcrb_pkg::mix_mode_t s5_mode;

  always_comb begin
    for (int k = 0; k < rcrb_pkg::NUM_CHAN; k++) begin
      case (mode_in)
        rcrb_pkg::MODE_DARK:  a_next[k] = MW'(chan_in[k]) * MW'(rcrb_pkg::DARK_GAIN);
        rcrb_pkg::MODE_BLEND: a_next[k] = MW'(chan_in[k]) * MW'(rcrb_pkg::BLEND_RAMP_GAIN);
        default:              a_next[k] = MW'(chan_in[k]);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en.s5) begin
      for (int k = 0; k < rcrb_pkg::NUM_CHAN; k++) begin
        s5_a[k] <= a_next[k];
      end
      s5_mode <= mode_in;
    end
  end

  // Stage 6: add grey share, reciprocal estimate.
  logic [MW-1:0]                    grey_term;
  logic [rcrb_pkg::MIX_RECIP_W-1:0] recip;
  logic [MW-1:0]                    x_next [rcrb_pkg::NUM_CHAN];
  logic [rcrb_pkg::MIX_PROD_W-1:0]  xprod  [rcrb_pkg::NUM_CHAN];
  logic [MW-1:0]                    s6_x   [rcrb_pkg::NUM_CHAN];
  rcrb_pkg::chan_t                  s6_q0  [rcrb_pkg::NUM_CHAN];
  rcrb_pkg::mix_mode_t              s6_mode;

  always_comb begin
    grey_term = '0;
    case (s5_mode)
      rcrb_pkg::MODE_BLEND: begin
        recip     = rcrb_pkg::MIX_RECIP_W'(rcrb_pkg::BLEND_RECIP);
        grey_term = MW'(grey) * MW'(rcrb_pkg::BLEND_GREY_GAIN);
      end
      rcrb_pkg::MODE_DARK: recip = rcrb_pkg::MIX_RECIP_W'(rcrb_pkg::DARK_RECIP);
      default:             recip = rcrb_pkg::MIX_RECIP_W'(rcrb_pkg::PASS_RECIP);
    endcase
    for (int k = 0; k < rcrb_pkg::NUM_CHAN; k++) begin
      x_next[k] = s5_a[k] + grey_term;
      xprod[k]  = rcrb_pkg::MIX_PROD_W'(x_next[k]) * rcrb_pkg::MIX_PROD_W'(recip);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s6) begin
      for (int k = 0; k < rcrb_pkg::NUM_CHAN; k++) begin
        s6_x[k]  <= x_next[k];
        s6_q0[k] <= rcrb_pkg::CHAN_W'(xprod[k] >> rcrb_pkg::RECIP_SHIFT);
      end
      s6_mode <= s5_mode;
    end
  end

  // Stage 7: estimate is exact or one low; fix it.
  logic [MW-1:0]    dvs;
  logic [MW-1:0]    rem [rcrb_pkg::NUM_CHAN];
  rcrb_pkg::pixel_t s7_chan;

  always_comb begin
    case (s6_mode)
      rcrb_pkg::MODE_BLEND: dvs = MW'(rcrb_pkg::BLEND_DIV);
      rcrb_pkg::MODE_DARK:  dvs = MW'(rcrb_pkg::DARK_DIV);
      default:              dvs = MW'(rcrb_pkg::PASS_DIV);
    endcase
    for (int k = 0; k < rcrb_pkg::NUM_CHAN; k++) begin
      rem[k] = s6_x[k] - MW'(s6_q0[k]) * dvs;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s7) begin
      for (int k = 0; k < rcrb_pkg::NUM_CHAN; k++) begin
        s7_chan[k] <= s6_q0[k] + rcrb_pkg::CHAN_W'(rem[k] >= dvs);
      end
    end
  end

  assign chan_out = s7_chan;

endmodule

// File: hw/rtl/rainfall_color_ramp_blend.sv
// Top level of the rainfall color ramp blend: config registers, pipeline control.
//
// Input stream s_*: one pixel request per transfer; s_tdata carries the rain
// level and terrain height, s_tuser the land flag. Output stream m_*: one RGB
// pixel per input request, in order. The cfg_* port writes overlay_enable
// (index 0) and max_elevation (index 1); write only while no request is in
// flight.
// Throughput: one request per clock unless m_tready stalls the output. Seven
// register stages: clamp and segment pick, channel products, reciprocal multiply,
// quotient fix, color scale, mix reciprocal multiply, mix fix. The terrain grey
// divider runs alongside in four stages of two quotient bits each.
// A request passes the stages in order and is offered on m_* from the last one.
// Each stage holds its request while the stage after it is full and stalled;
// empty stages keep filling, so s_tready stays high while any stage is empty.
// Reset clears all stage valid bits, overlay_enable to 0 and max_elevation to
// all ones.
`include "assert_macros.svh"

module rainfall_color_ramp_blend #(
  parameter int RAIN_FRAC_BITS = rcrb_pkg::RAIN_FRAC_BITS_DEF,
  parameter int HEIGHT_BITS    = rcrb_pkg::HEIGHT_BITS_DEF,
  localparam int IN_W          = RAIN_FRAC_BITS + 1 + HEIGHT_BITS,
  localparam int IN_TDATA_W    = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W         = rcrb_pkg::NUM_CHAN * rcrb_pkg::CHAN_W,
  localparam int OUT_TDATA_W   = ((OUT_W + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // rain_level, height_sample, zero fill
  input  logic [IN_TDATA_W-1:0]           s_tdata,
  // land_flag
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // red, green, blue
  output logic [OUT_TDATA_W-1:0]          m_tdata,
  input  logic                            cfg_we,
  input  logic [rcrb_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [HEIGHT_BITS-1:0]          cfg_wdata
);

  localparam int NS = rcrb_pkg::NUM_STAGES;

  logic                   overlay_enable;
  logic [HEIGHT_BITS-1:0] max_elevation;

  always_ff @(posedge clk) begin
    if (rst) begin
      overlay_enable <= 1'b0;
      max_elevation  <= '1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        rcrb_pkg::REG_OVERLAY_ENABLE: overlay_enable <= cfg_wdata[0];
        rcrb_pkg::REG_MAX_ELEVATION:  max_elevation  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage valid bits with a ready chain; a stage loads when it is empty or drains.
  logic [NS-1:0]       vld;
  logic [NS-1:0]       vld_in;
  logic [NS:0]         rdy;
  rcrb_pkg::stage_en_t en;

  always_comb begin
    rdy[NS] = m_tready;
    for (int i = NS - 1; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i + 1];
    end
  end

  assign vld_in = {vld[NS-2:0], s_tvalid};
  assign en     = rcrb_pkg::stage_en_t'(rdy[NS-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld_in[i];
        end
      end
    end
  end

  assign s_tready = rdy[0];
  assign m_tvalid = vld[NS-1];

  logic [RAIN_FRAC_BITS:0]  rain_level;
  logic [HEIGHT_BITS-1:0]   height_sample;
  rcrb_pkg::pixel_t         ramp_chan;
  rcrb_pkg::mix_mode_t      ramp_mode;
  rcrb_pkg::chan_t          grey;
  rcrb_pkg::pixel_t         pix_out;

  assign rain_level    = s_tdata[RAIN_FRAC_BITS:0];
  assign height_sample = s_tdata[RAIN_FRAC_BITS + 1 +: HEIGHT_BITS];

  rcrb_ramp #(
    .RAIN_FRAC_BITS (RAIN_FRAC_BITS)
  ) u_ramp (
    .clk            (clk),
    .en             (en),
    .rain_level     (rain_level),
    .land_flag      (s_tuser),
    .overlay_enable (overlay_enable),
    .chan           (ramp_chan),
    .mode           (ramp_mode)
  );

  rcrb_grey #(
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_grey (
    .clk           (clk),
    .en            (en),
    .height_sample (height_sample),
    .max_elevation (max_elevation),
    .grey          (grey)
  );

  rcrb_blend u_blend (
    .clk      (clk),
    .en       (en),
    .chan_in  (ramp_chan),
    .mode_in  (ramp_mode),
    .grey     (grey),
    .chan_out (pix_out)
  );

  assign m_tdata = OUT_TDATA_W'(pix_out);

  `RCRB_ASSERT_ALWAYS(a_rst_flush, clk, rst |=> (vld == '0), "valid bits not cleared by reset")
  `RCRB_ASSERT(a_bubble_ready, clk, rst, !(&vld) |-> s_tready, "not ready with an empty stage")
  `RCRB_ASSERT(a_stage_hold, clk, rst, (vld[3] && !rdy[4]) |=> vld[3], "stalled request dropped")
  `RCRB_ASSERT(a_cfg_max_elev, clk, rst, (cfg_we && (cfg_addr == rcrb_pkg::REG_MAX_ELEVATION)) |=> (max_elevation == $past(cfg_wdata)), "max_elevation write lost")

endmodule
